>>> rtl/sefp_pkg.sv
package sefp_pkg;

  // Default width of projections and results (signed Q16.16)
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Scale register: unsigned Q8.16
  localparam int unsigned SCALE_W     = 24;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd4587520;

  // h = round(s * k / 2^17): Q16.16 times Q8.16, halved
  localparam int unsigned FRAC_SHIFT  = 17;

  localparam int unsigned KIND_W      = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPHERE   = 3'd0,
    KIND_CAPSULE  = 3'd1,
    KIND_BOX      = 3'd2,
    KIND_CYLINDER = 3'd3,
    KIND_OTHER    = 3'd4
  } shape_kind_e;

endpackage

>>> rtl/shape_extent_from_projections.sv
// Shape extent from six support projections.
//
// Input stream (s_axis_*): one transfer per shape carries the projections
// along +X, -X, +Y, -Y, +Z, -Z in tdata and the shape kind in tuser.
// Output stream (m_axis_*): one transfer per shape with the longest half
// extent, the thinnest positive one, the Z half extent and the bounding
// radius picked by kind (root of squares for box and cylinder).
// Scale register: write cfg_wdata_i with cfg_we_i high while the block is idle.
//
// The pipeline has three stages of scaled half extents, two of squares and
// selection, one per root bit in the square-root pipeline, and the output
// register. Throughput is one shape per cycle while the receiver takes
// results. Every stage has its own valid bit, so while the receiver stalls,
// empty stages keep filling and tready drops only once the pipeline is
// full; nothing is lost or repeated. Reset empties the pipeline and loads
// the scale register with 70.0.
module shape_extent_from_projections #(
  parameter int unsigned VALUE_WIDTH = sefp_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned IN_W  = ((6 * VALUE_WIDTH + 7) / 8) * 8,
  parameter int unsigned OUT_W = ((4 * VALUE_WIDTH - 1 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sefp_pkg::SCALE_W-1:0]  cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // proj_pos_x, proj_neg_x, proj_pos_y, proj_neg_y, proj_pos_z, proj_neg_z
  input  logic [IN_W-1:0]               s_axis_tdata,
  // shape_kind
  input  logic [sefp_pkg::KIND_W-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // long_half, thin_half, vertical_half, bound_radius
  output logic [OUT_W-1:0]              m_axis_tdata
);
  import sefp_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned TW = 4 * VW;
  localparam logic [VW:0] ROOT_MAX = {2'b00, {(VW - 1){1'b1}}};

  logic [SCALE_W-1:0] scale_q;

  logic [VW-1:0]      pos [3];
  logic [VW-1:0]      neg [3];
  logic               h_valid, h_ready;
  logic [VW-1:0]      half [3];
  logic [KIND_W-1:0]  h_kind;
  logic               r_valid, r_ready;
  logic [2*VW-1:0]    sumsq;
  logic [TW-1:0]      r_tag;
  logic               q_valid, q_ready;
  logic [VW-1:0]      root;
  logic [VW+1:0]      rem;
  logic [TW-1:0]      q_tag;

  logic               out_v_q;
  logic [OUT_W-1:0]   out_q;
  logic [OUT_W-1:0]   out_d;
  logic [VW:0]        rounded;
  logic [VW-1:0]      root_sat;
  logic [VW-1:0]      radius;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign pos[a] = s_axis_tdata[2*a*VW +: VW];
    assign neg[a] = s_axis_tdata[(2*a+1)*VW +: VW];
  end

  sefp_half #(.VW(VW)) u_half (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pos_i       (pos),
    .neg_i       (neg),
    .kind_i      (s_axis_tuser),
    .out_valid_o (h_valid),
    .out_ready_i (h_ready),
    .half_o      (half),
    .kind_o      (h_kind)
  );

  sefp_reduce #(.VW(VW)) u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (h_valid),
    .in_ready_o  (h_ready),
    .half_i      (half),
    .kind_i      (h_kind),
    .out_valid_o (r_valid),
    .out_ready_i (r_ready),
    .sumsq_o     (sumsq),
    .tag_o       (r_tag)
  );

  sefp_sqrt #(.VW(VW), .TW(TW)) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (r_valid),
    .in_ready_o  (r_ready),
    .n_i         (sumsq),
    .tag_i       (r_tag),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .root_o      (root),
    .rem_o       (rem),
    .tag_o       (q_tag)
  );

  // round the root to nearest: bump when the remainder exceeds the root
  always_comb begin
    rounded  = {1'b0, root} + (VW + 1)'(rem > (VW + 2)'(root));
    root_sat = (rounded > ROOT_MAX) ? ROOT_MAX[VW-1:0] : rounded[VW-1:0];
    radius   = q_tag[TW-1] ? root_sat : q_tag[TW-2:3*VW-1];
    out_d    = OUT_W'({radius, q_tag[3*VW-2:0]});
  end

  assign q_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (q_ready) begin
      out_v_q <= q_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_ready) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> rtl/sefp_half.sv
module sefp_half #(
  parameter int unsigned VW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sefp_pkg::SCALE_W-1:0]  scale_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [VW-1:0]                 pos_i [3],
  input  logic [VW-1:0]                 neg_i [3],
  input  logic [sefp_pkg::KIND_W-1:0]   kind_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [VW-1:0]                 half_o [3],
  output logic [sefp_pkg::KIND_W-1:0]   kind_o
);
  import sefp_pkg::*;

  // magnitude of pos+neg, padded so that the high slice is never empty
  localparam int unsigned MW  = (VW + 1 > SCALE_W) ? VW + 1 : SCALE_W + 1;
  localparam int unsigned LW  = 2 * SCALE_W;
  localparam int unsigned SH  = SCALE_W - FRAC_SHIFT;
  localparam int unsigned RW  = MW + SH + 1;
  localparam logic [LW:0] RND = (LW + 1)'(1) << (FRAC_SHIFT - 1);
  localparam logic [RW-1:0] POS_LIM = {{(RW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic [RW-1:0] NEG_LIM = POS_LIM + RW'(1);
  localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW - 1){1'b0}}};

  logic [2:0] v_q;
  logic [3:0] rdy;

  logic [MW-1:0]        m_q   [3];
  logic [2:0]           sgn1_q;
  logic [KIND_W-1:0]    kind1_q;
  logic [LW-1:0]        lo_q  [3];
  logic [MW-1:0]        hi_q  [3];
  logic [2:0]           sgn2_q;
  logic [KIND_W-1:0]    kind2_q;
  logic [VW-1:0]        h_q   [3];
  logic [KIND_W-1:0]    kind3_q;

  always_comb begin
    rdy[3] = out_ready_i;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];
  assign half_o      = h_q;
  assign kind_o      = kind3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [VW:0]   sum;
    logic [VW:0]   mag;
    logic [LW-1:0] lo_d;
    logic [MW-1:0] hi_d;
    logic [LW:0]   lsum;
    logic [RW-1:0] r;
    logic [RW-1:0] lim;
    logic [VW-1:0] h_d;

    // stage 1: exact sum and its magnitude
    always_comb begin
      sum = {pos_i[l][VW-1], pos_i[l]} + {neg_i[l][VW-1], neg_i[l]};
      mag = sum[VW] ? (~sum + (VW + 1)'(1)) : sum;
    end

    // stage 2: split product, low 24 bits and the rest
    always_comb begin
      lo_d = m_q[l][SCALE_W-1:0] * scale_i;
      hi_d = m_q[l][MW-1:SCALE_W] * scale_i;
    end

    // stage 3: recombine with rounding, restore sign, saturate
    always_comb begin
      lsum = {1'b0, lo_q[l]} + RND;
      r    = RW'({hi_q[l], {SH{1'b0}}}) + RW'(lsum[LW:FRAC_SHIFT]);
      lim  = sgn2_q[l] ? NEG_LIM : POS_LIM;
      if (r > lim) begin
        h_d = sgn2_q[l] ? VAL_MIN : VAL_MAX;
      end else begin
        h_d = sgn2_q[l] ? (~r[VW-1:0] + VW'(1)) : r[VW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[0]) begin
        m_q[l]    <= MW'(mag);
        sgn1_q[l] <= sum[VW];
      end
      if (rdy[1]) begin
        lo_q[l]   <= lo_d;
        hi_q[l]   <= hi_d;
        sgn2_q[l] <= sgn1_q[l];
      end
      if (rdy[2]) begin
        h_q[l] <= h_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) kind1_q <= kind_i;
    if (rdy[1]) kind2_q <= kind1_q;
    if (rdy[2]) kind3_q <= kind2_q;
  end

endmodule

>>> rtl/sefp_reduce.sv
module sefp_reduce #(
  parameter int unsigned VW = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [VW-1:0]                half_i [3],
  input  logic [sefp_pkg::KIND_W-1:0]  kind_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2*VW-1:0]              sumsq_o,
  output logic [4*VW-1:0]              tag_o
);
  import sefp_pkg::*;

  localparam int unsigned TW = 4 * VW;

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic [2*VW-1:0] sq_d [3];
  logic [2*VW-1:0] sq_q [3];
  logic            box_d, box_q;
  logic            xgty_d, xgty_q;
  logic [TW-1:0]   tag_d, tag1_q, tag2_q;
  logic [2*VW-1:0] sumsq_d, sumsq_q;

  logic signed [VW-1:0] hx, hy, hz;
  logic signed [VW-1:0] longest;
  logic signed [VW-1:0] alt;
  logic [VW-1:0]        thin;
  logic                 have;
  logic                 use_root;

  always_comb begin
    rdy[2] = out_ready_i;
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[1];
  assign sumsq_o     = sumsq_q;
  assign tag_o       = tag2_q;

  for (genvar l = 0; l < 3; l++) begin : g_sq
    logic [VW-1:0] mag;
    always_comb begin
      mag      = half_i[l][VW-1] ? (~half_i[l] + VW'(1)) : half_i[l];
      sq_d[l]  = mag * mag;
    end
  end

  // stage 1: extremes, kind decode, squares
  always_comb begin
    hx      = half_i[0];
    hy      = half_i[1];
    hz      = half_i[2];
    xgty_d  = hx > hy;
    longest = hx;
    if (hy > longest) longest = hy;
    if (hz > longest) longest = hz;

    thin = '0;
    have = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (!half_i[l][VW-1] && (half_i[l] != '0) && (!have || half_i[l] < thin)) begin
        thin = half_i[l];
        have = 1'b1;
      end
    end

    use_root = 1'b0;
    box_d    = 1'b0;
    alt      = longest;
    unique case (kind_i)
      KIND_SPHERE:   alt = hx;
      KIND_BOX: begin
        use_root = 1'b1;
        box_d    = 1'b1;
      end
      KIND_CYLINDER: use_root = 1'b1;
      default:       alt = longest;
    endcase

    tag_d = {use_root, alt, hz, thin[VW-2:0], longest};
  end

  // stage 2: sum of squares; the wider of X and Y is picked by sign-aware compare
  always_comb begin
    if (box_q) begin
      sumsq_d = sq_q[0] + sq_q[1] + sq_q[2];
    end else begin
      sumsq_d = (xgty_q ? sq_q[0] : sq_q[1]) + sq_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sq_q   <= sq_d;
      box_q  <= box_d;
      xgty_q <= xgty_d;
      tag1_q <= tag_d;
    end
    if (rdy[1]) begin
      sumsq_q <= sumsq_d;
      tag2_q  <= tag1_q;
    end
  end

endmodule

>>> rtl/sefp_sqrt.sv
module sefp_sqrt #(
  parameter int unsigned VW = 32,
  parameter int unsigned TW = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2*VW-1:0]   n_i,
  input  logic [TW-1:0]     tag_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VW-1:0]     root_o,
  output logic [VW+1:0]     rem_o,
  output logic [TW-1:0]     tag_o
);

  // one result bit per stage, restoring digit recurrence
  logic [VW-1:0]   v_q;
  logic [VW:0]     rdy;
  logic [2*VW-1:0] n_q    [VW];
  logic [VW+1:0]   rem_q  [VW];
  logic [VW-1:0]   root_q [VW];
  logic [TW-1:0]   tag_q  [VW];

  always_comb begin
    rdy[VW] = out_ready_i;
    for (int k = VW - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[VW-1];
  assign root_o      = root_q[VW-1];
  assign rem_o       = rem_q[VW-1];
  assign tag_o       = tag_q[VW-1];

  for (genvar k = 0; k < VW; k++) begin : g_stage
    logic            v_in;
    logic [2*VW-1:0] n_in;
    logic [VW-1:0]   rem_in;
    logic [VW-1:0]   root_in;
    logic [TW-1:0]   tag_in;
    logic [VW+1:0]   rem_sh;
    logic [VW+1:0]   trial;
    logic            take;

    if (k == 0) begin : g_first
      assign v_in    = in_valid_i;
      assign n_in    = n_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1][VW-1:0];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, n_in[2*VW-1:2*VW-2]};
      trial  = {root_in, 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        n_q[k]    <= {n_in[2*VW-3:0], 2'b00};
        rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[VW-2:0], take};
        tag_q[k]  <= tag_in;
      end
    end
  end

endmodule
